@@ sv/cdef_pkg.sv @@
`timescale 1ns / 1ps

package cdef_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int MIN_SIZE = 3;
  localparam int MOD_BASE = 255;

  localparam int PIX_W = 8;
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int SUM_W = PIX_W + 1;

  localparam int WIDTH_REG_W = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_INDEX_W = 2;

  localparam int IN_TDATA_W = 8;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_PAD_W = OUT_TDATA_W - COL_W - ROW_W - PIX_W;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic [COL_W-1:0] WIDTH_LAST_RESET = COL_W'(640 - 1);
  localparam logic [ROW_W-1:0] HEIGHT_LAST_RESET = ROW_W'(480 - 1);

  // One pending result: the window operands, or the corner pixel in down.
  typedef struct packed {
    logic             corner;
    logic             last;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [PIX_W-1:0] left;
    logic [PIX_W-1:0] right;
    logic [PIX_W-1:0] up;
    logic [PIX_W-1:0] down;
  } job_t;

endpackage

@@ sv/cdef_front.sv @@
`timescale 1ns / 1ps

module cdef_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cdef_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [cdef_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [cdef_pkg::PIX_W-1:0]        pixel,
  input  logic                              q_full,
  output logic                              push,
  output cdef_pkg::job_t                    job
);

  // Each line store word holds the row above in the upper byte and the row
  // two above in the lower byte.
  logic [2*cdef_pkg::PIX_W-1:0] line_mem [cdef_pkg::MAX_WIDTH];
  logic [2*cdef_pkg::PIX_W-1:0] line_rd;
  logic [2*cdef_pkg::PIX_W-1:0] line_cur;
  logic [cdef_pkg::PIX_W-1:0]   left_pix;

  logic [cdef_pkg::COL_W-1:0] col;
  logic [cdef_pkg::ROW_W-1:0] row;
  logic [cdef_pkg::COL_W-1:0] width_last;
  logic [cdef_pkg::ROW_W-1:0] height_last;

  logic [cdef_pkg::COL_W-1:0] width_last_next;
  logic [cdef_pkg::ROW_W-1:0] height_last_next;
  logic [cdef_pkg::WIDTH_REG_W-1:0]  width_val;
  logic [cdef_pkg::HEIGHT_REG_W-1:0] height_val;
  logic [cdef_pkg::COL_W-1:0] rd_addr;

  logic accept;
  logic cfg_hit;
  logic last_col;
  logic last_row;
  logic interior;
  logic corner;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign accept    = in_valid && !q_full;

  // Only a write to a mapped register starts a new frame.
  assign cfg_hit = cfg_valid &&
                   (cfg_index inside {cdef_pkg::REG_IMAGE_WIDTH, cdef_pkg::REG_IMAGE_HEIGHT});

  assign last_col = (col == width_last);
  assign last_row = (row == height_last);
  assign interior = (row >= cdef_pkg::ROW_W'(2)) && (col != '0) && !last_col;
  assign corner   = ((col == '0) || last_col) && ((row == '0) || last_row);
  assign push     = accept && (interior || corner);

  always_comb begin
    width_val  = cfg_data[cdef_pkg::WIDTH_REG_W-1:0];
    height_val = cfg_data[cdef_pkg::HEIGHT_REG_W-1:0];
    if (width_val < cdef_pkg::WIDTH_REG_W'(cdef_pkg::MIN_SIZE)) begin
      width_last_next = cdef_pkg::COL_W'(cdef_pkg::MIN_SIZE - 1);
    end else if (width_val > cdef_pkg::WIDTH_REG_W'(cdef_pkg::MAX_WIDTH)) begin
      width_last_next = cdef_pkg::COL_W'(cdef_pkg::MAX_WIDTH - 1);
    end else begin
      width_last_next = cdef_pkg::COL_W'(width_val - cdef_pkg::WIDTH_REG_W'(1));
    end
    if (height_val < cdef_pkg::HEIGHT_REG_W'(cdef_pkg::MIN_SIZE)) begin
      height_last_next = cdef_pkg::ROW_W'(cdef_pkg::MIN_SIZE - 1);
    end else if (height_val > cdef_pkg::HEIGHT_REG_W'(cdef_pkg::MAX_HEIGHT)) begin
      height_last_next = cdef_pkg::ROW_W'(cdef_pkg::MAX_HEIGHT - 1);
    end else begin
      height_last_next = cdef_pkg::ROW_W'(height_val - cdef_pkg::HEIGHT_REG_W'(1));
    end
  end

  // Fetch two columns ahead so the right neighbor is ready when a pixel arrives.
  always_comb begin
    if (last_col) begin
      rd_addr = cdef_pkg::COL_W'(1);
    end else if (col == width_last - cdef_pkg::COL_W'(1)) begin
      rd_addr = '0;
    end else begin
      rd_addr = col + cdef_pkg::COL_W'(2);
    end
  end

  always_comb begin
    job.corner = corner;
    job.last   = last_col && last_row;
    job.col    = col;
    job.row    = corner ? row : row - cdef_pkg::ROW_W'(1);
    job.left   = left_pix;
    job.right  = line_rd[2*cdef_pkg::PIX_W-1:cdef_pkg::PIX_W];
    job.up     = line_cur[cdef_pkg::PIX_W-1:0];
    job.down   = pixel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col         <= '0;
      row         <= '0;
      width_last  <= cdef_pkg::WIDTH_LAST_RESET;
      height_last <= cdef_pkg::HEIGHT_LAST_RESET;
    end else if (cfg_hit) begin
      col <= '0;
      row <= '0;
      case (cfg_index)
        cdef_pkg::REG_IMAGE_WIDTH:  width_last  <= width_last_next;
        cdef_pkg::REG_IMAGE_HEIGHT: height_last <= height_last_next;
        default: ;
      endcase
    end else if (accept) begin
      if (last_col) begin
        col <= '0;
        row <= last_row ? '0 : row + cdef_pkg::ROW_W'(1);
      end else begin
        col <= col + cdef_pkg::COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      line_mem[col] <= {pixel, line_cur[2*cdef_pkg::PIX_W-1:cdef_pkg::PIX_W]};
      line_rd       <= line_mem[rd_addr];
      line_cur      <= line_rd;
      left_pix      <= line_cur[2*cdef_pkg::PIX_W-1:cdef_pkg::PIX_W];
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst) (col <= width_last) && (row <= height_last))
    else $error("position outside the frame");
  assert property (@(posedge clk) disable iff (rst)
      accept && last_col && !last_row && !cfg_valid
      |=> (col == '0) && (row == $past(row) + cdef_pkg::ROW_W'(1)))
    else $error("row advance failed at end of line");
  assert property (@(posedge clk) disable iff (rst) push |-> !(interior && corner))
    else $error("pixel classified as both interior and corner");
`endif

endmodule

@@ sv/cdef_queue.sv @@
`timescale 1ns / 1ps

module cdef_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  cdef_pkg::job_t push_data,
  output logic           full,
  input  logic           pop,
  output cdef_pkg::job_t pop_data,
  output logic           empty
);

  cdef_pkg::job_t entries [cdef_pkg::QUEUE_DEPTH];
  logic [cdef_pkg::QPTR_W-1:0] wr_ptr;
  logic [cdef_pkg::QPTR_W-1:0] rd_ptr;
  logic [cdef_pkg::QCNT_W-1:0] count;

  assign full     = (count == cdef_pkg::QCNT_W'(cdef_pkg::QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + cdef_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + cdef_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + cdef_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - cdef_pkg::QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("transfer into a full queue");
  assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("read from an empty queue");
`endif

endmodule

@@ sv/cdef_back.sv @@
`timescale 1ns / 1ps

module cdef_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              empty,
  input  cdef_pkg::job_t                    head,
  output logic                              pop,
  output logic                              m_valid,
  input  logic                              m_ready,
  output logic [cdef_pkg::OUT_TDATA_W-1:0]  m_data,
  output logic                              m_last
);

  logic                       out_valid;
  logic                       out_last;
  logic [cdef_pkg::COL_W-1:0] out_col;
  logic [cdef_pkg::ROW_W-1:0] out_row;
  logic [cdef_pkg::PIX_W-1:0] out_value;

  logic [cdef_pkg::PIX_W-1:0] diff_h;
  logic [cdef_pkg::PIX_W-1:0] diff_v;
  logic [cdef_pkg::SUM_W-1:0] sum;
  logic [cdef_pkg::PIX_W-1:0] value_next;

  assign pop = !empty && (!out_valid || m_ready);

  always_comb begin
    diff_h = (head.left >= head.right) ? head.left - head.right : head.right - head.left;
    diff_v = (head.up >= head.down) ? head.up - head.down : head.down - head.up;
    sum    = {1'b0, diff_h} + {1'b0, diff_v};
    if (head.corner) begin
      value_next = (head.down == cdef_pkg::PIX_W'(cdef_pkg::MOD_BASE)) ? '0 : head.down;
    end else if (sum >= cdef_pkg::SUM_W'(2 * cdef_pkg::MOD_BASE)) begin
      value_next = cdef_pkg::PIX_W'(sum - cdef_pkg::SUM_W'(2 * cdef_pkg::MOD_BASE));
    end else if (sum >= cdef_pkg::SUM_W'(cdef_pkg::MOD_BASE)) begin
      value_next = cdef_pkg::PIX_W'(sum - cdef_pkg::SUM_W'(cdef_pkg::MOD_BASE));
    end else begin
      value_next = sum[cdef_pkg::PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (m_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_last  <= head.last;
      out_col   <= head.col;
      out_row   <= head.row;
      out_value <= value_next;
    end
  end

  assign m_valid = out_valid;
  assign m_last  = out_last;
  assign m_data  = {{cdef_pkg::OUT_PAD_W{1'b0}}, out_value, out_row, out_col};

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst)
      out_valid |-> (out_value != cdef_pkg::PIX_W'(cdef_pkg::MOD_BASE)))
    else $error("result not reduced below the modulus");
`endif

endmodule

@@ sv/central_difference_edge_filter_unit.sv @@
// A result passes through a queue entry and then the output register before it reaches the master side.
// Throughput: one pixel per cycle unless the queue is full; line store reads two columns ahead, one port per cycle.
// A four-entry queue between the window front end and the result stage absorbs output stalls.
// Reset: position returns to column 0, row 0, width 640 and height 480.
// The line stores are not cleared; each entry is written before it is read in a frame.
`timescale 1ns / 1ps

module central_difference_edge_filter_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cdef_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [cdef_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // pixel
  input  logic [cdef_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // out_col, out_row, result_value, zero padding
  output logic [cdef_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  output logic                              m_axis_tlast
);

  cdef_pkg::job_t push_job;
  cdef_pkg::job_t head_job;
  logic push;
  logic pop;
  logic q_full;
  logic q_empty;

  cdef_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .pixel     (s_axis_tdata[cdef_pkg::PIX_W-1:0]),
    .q_full    (q_full),
    .push      (push),
    .job       (push_job)
  );

  cdef_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_job),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (head_job),
    .empty     (q_empty)
  );

  cdef_back u_back (
    .clk     (clk),
    .rst     (rst),
    .empty   (q_empty),
    .head    (head_job),
    .pop     (pop),
    .m_valid (m_axis_tvalid),
    .m_ready (m_axis_tready),
    .m_data  (m_axis_tdata),
    .m_last  (m_axis_tlast)
  );

endmodule

@@ sim/edge_filter_result_checker.sv @@
`timescale 1ns / 1ps

module edge_filter_result_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [cdef_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [cdef_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  // pixel
  input  logic [cdef_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // out_col, out_row, result_value, zero padding
  input  logic [cdef_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input  logic                              m_axis_tlast,
  output int                                errors,
  output int                                pending
);

  import cdef_pkg::*;

  localparam int RESET_WIDTH = 640;
  localparam int RESET_HEIGHT = 480;
  localparam int REPORT_LIMIT = 10;
  localparam int VALUE_LSB = COL_W + ROW_W;
  localparam int PAD_LSB = VALUE_LSB + PIX_W;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [PIX_W-1:0] value;
    logic             last;
  } edge_result_t;

  edge_result_t           edge_results_due[$];
  logic [PIX_W-1:0]       line_above[MAX_WIDTH];
  logic [PIX_W-1:0]       line_above2[MAX_WIDTH];
  logic [WIDTH_REG_W-1:0] width_reg;
  logic [HEIGHT_REG_W-1:0] height_reg;
  int unsigned            next_col;
  int unsigned            next_row;
  int                     fail_count = 0;

  function automatic int unsigned clamp_size(input int unsigned value, input int unsigned hi);
    if (value < MIN_SIZE) return MIN_SIZE;
    if (value > hi) return hi;
    return value;
  endfunction

  function automatic int unsigned abs_gap(input int unsigned a, input int unsigned b);
    return (a >= b) ? a - b : b - a;
  endfunction

  function automatic void report_failure(input string text);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("%s", text);
  endfunction

  // Advances the raster position by one pixel and queues the result it causes, if any.
  function automatic void predict_edge_result(input logic [PIX_W-1:0] px);
    int unsigned  w;
    int unsigned  h;
    int unsigned  x;
    int unsigned  y;
    int unsigned  total;
    logic         at_last_col;
    logic         at_last_row;
    edge_result_t res;
    w = clamp_size(width_reg, MAX_WIDTH);
    h = clamp_size(height_reg, MAX_HEIGHT);
    x = (next_col >= w) ? w - 1 : next_col;
    y = (next_row >= h) ? h - 1 : next_row;
    at_last_col = (x == w - 1);
    at_last_row = (y == h - 1);
    if (y >= 2 && x >= 1 && !at_last_col) begin
      total = abs_gap(line_above2[x-1], line_above[x+1]) + abs_gap(line_above2[x], px);
      res.col = COL_W'(x);
      res.row = ROW_W'(y - 1);
      res.value = PIX_W'(total % MOD_BASE);
      res.last = 1'b0;
      edge_results_due.push_back(res);
    end else if ((x == 0 || at_last_col) && (y == 0 || at_last_row)) begin
      res.col = COL_W'(x);
      res.row = ROW_W'(y);
      res.value = PIX_W'(px % MOD_BASE);
      res.last = at_last_col && at_last_row;
      edge_results_due.push_back(res);
    end
    line_above2[x] = line_above[x];
    line_above[x] = px;
    if (at_last_col) begin
      next_col = 0;
      next_row = at_last_row ? 0 : y + 1;
    end else begin
      next_col = x + 1;
      next_row = y;
    end
  endfunction

  always @(posedge clk) begin : watch
    edge_result_t want;
    edge_result_t got;
    logic [OUT_PAD_W-1:0] pad;
    if (rst) begin
      edge_results_due.delete();
      foreach (line_above[i]) begin
        line_above[i] = '0;
        line_above2[i] = '0;
      end
      width_reg = WIDTH_REG_W'(RESET_WIDTH);
      height_reg = HEIGHT_REG_W'(RESET_HEIGHT);
      next_col = 0;
      next_row = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.col = m_axis_tdata[COL_W-1:0];
        got.row = m_axis_tdata[COL_W +: ROW_W];
        got.value = m_axis_tdata[VALUE_LSB +: PIX_W];
        got.last = m_axis_tlast;
        pad = m_axis_tdata[PAD_LSB +: OUT_PAD_W];
        if (edge_results_due.size() == 0) begin
          report_failure($sformatf("unexpected result: col %0d row %0d value %0d last %0b",
                                   got.col, got.row, got.value, got.last));
        end else begin
          want = edge_results_due.pop_front();
          if (got !== want || pad !== '0) begin
            report_failure($sformatf({"result mismatch: expected col %0d row %0d value %0d ",
                                      "last %0b, got col %0d row %0d value %0d last %0b pad %0h"},
                                     want.col, want.row, want.value, want.last,
                                     got.col, got.row, got.value, got.last, pad));
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_IMAGE_WIDTH: begin
            width_reg = cfg_data[WIDTH_REG_W-1:0];
            next_col = 0;
            next_row = 0;
          end
          REG_IMAGE_HEIGHT: begin
            height_reg = cfg_data[HEIGHT_REG_W-1:0];
            next_col = 0;
            next_row = 0;
          end
          default: begin
          end
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) predict_edge_result(s_axis_tdata[PIX_W-1:0]);
    end
    errors <= fail_count;
    pending <= edge_results_due.size();
  end

endmodule

@@ sim/central_difference_edge_filter_unit_test.sv @@
`timescale 1ns / 1ps

module central_difference_edge_filter_unit_test;

  import cdef_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_RESERVED_2 = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_RESERVED_3 = 2'd3;
  localparam int CYCLE_LIMIT = 500_000;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int RANDOM_ITEMS = 100;
  localparam int CLAMP_RUN_ITEMS = 40;
  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  typedef enum logic [1:0] {
    PACE_SLOW_SINK,
    PACE_SLOW_SOURCE,
    PACE_FULL_RATE
  } pace_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_INDEX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [IN_TDATA_W-1:0]    s_axis_tdata = '0;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]   m_axis_tdata;
  logic                     m_axis_tlast;
  int                       errors;
  int                       pending;
  pace_t                    pace = PACE_SLOW_SINK;
  logic                     hold_req = 1'b0;
  logic                     hold_taken = 1'b0;
  int                       hold_left = 0;
  int unsigned              cycle_count = 0;

  always #4 clk = ~clk;

  central_difference_edge_filter_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  edge_filter_result_checker u_result_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .errors        (errors),
    .pending       (pending)
  );

  function automatic int idle_percent(input pace_t p, input bit sink_side);
    case (p)
      PACE_SLOW_SINK:   return sink_side ? 61 : 11;
      PACE_SLOW_SOURCE: return sink_side ? 11 : 61;
      default:          return 0;
    endcase
  endfunction

  function automatic int frame_size(input int value, input int hi);
    if (value < MIN_SIZE) return MIN_SIZE;
    if (value > hi) return hi;
    return value;
  endfunction

  function automatic logic [PIX_W-1:0] random_pixel();
    case ($urandom_range(7))
      0:       return '0;
      1:       return PIX_MAX;
      default: return PIX_W'($urandom_range(255));
    endcase
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_taken != hold_req) begin
      hold_taken <= hold_req;
      hold_left <= HOLD_OFF_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= idle_percent(pace, 1'b1));
    end
  end

  task automatic send_pixel(input logic [PIX_W-1:0] px);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_percent(pace, 1'b0)) gap++;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= px;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_frame(input int w, input int h, input int count, input bit hold_sink);
    drain();
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
    if (hold_sink) hold_req <= ~hold_req;
    repeat (count) send_pixel(random_pixel());
  endtask

  // Mostly whole frames of small sizes, with some cut short and some running into the next.
  task automatic run_random_frames(input int target);
    int sent;
    int count;
    int w;
    int h;
    sent = 0;
    while (sent < target) begin
      w = ($urandom_range(3) == 0) ? $urandom_range(2) : $urandom_range(3, 12);
      h = ($urandom_range(3) == 0) ? $urandom_range(2) : $urandom_range(3, 6);
      count = frame_size(w, MAX_WIDTH) * frame_size(h, MAX_HEIGHT);
      case ($urandom_range(9))
        0, 1:    count = $urandom_range(1, count - 1);
        2:       count = 2 * count;
        default: begin
        end
      endcase
      drain();
      if ($urandom_range(9) == 0) begin
        write_reg($urandom_range(1) ? REG_RESERVED_2 : REG_RESERVED_3, CFG_DATA_W'($urandom));
      end
      write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
      write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
      repeat (count) send_pixel(random_pixel());
      sent += count;
    end
  endtask

  initial begin
    logic [PIX_W-1:0] frame_a[9];
    logic [PIX_W-1:0] frame_b[9];
    frame_a = '{8'd254, 8'd7, 8'd255, 8'd0, 8'd255, 8'd9, 8'd255, 8'd0, 8'd1};
    frame_b = '{8'd3, 8'd0, 8'd128, 8'd0, 8'd200, 8'd255, 8'd255, 8'd255, 8'd0};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // A few pixels at the reset size; the top-left corner comes back at once.
    send_pixel(PIX_MAX);
    send_pixel('0);
    send_pixel(8'd17);
    drain();
    write_reg(REG_IMAGE_WIDTH, '0);
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(2));
    foreach (frame_a[i]) send_pixel(frame_a[i]);
    drain();
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(2));
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(1));
    for (int i = 0; i < 4; i++) send_pixel(frame_b[i]);
    // A write to an unmapped index must leave the frame position alone.
    drain();
    write_reg(REG_RESERVED_2, '1);
    for (int i = 4; i < 9; i++) send_pixel(frame_b[i]);

    run_random_frames(RANDOM_ITEMS);
    drain();
    pace <= PACE_SLOW_SOURCE;
    run_random_frames(RANDOM_ITEMS);
    drain();
    pace <= PACE_FULL_RATE;
    run_frame(12, 6, 72, 1'b1);
    run_frame(MAX_WIDTH, MAX_HEIGHT, CLAMP_RUN_ITEMS, 1'b0);
    run_frame(2047, 0, CLAMP_RUN_ITEMS, 1'b0);
    run_frame(MIN_SIZE, 8191, CLAMP_RUN_ITEMS, 1'b0);
    run_random_frames(RANDOM_ITEMS);

    drain();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/cdef_pkg.sv
sv/cdef_front.sv
sv/cdef_queue.sv
sv/cdef_back.sv
sv/central_difference_edge_filter_unit.sv
sim/edge_filter_result_checker.sv
sim/central_difference_edge_filter_unit_test.sv
